// ===== rtl/core/jse_pkg.sv =====
// package for the json string escaper: request and result structs, the queued job
// descriptor shared by the front and back parts, and the character constants of the front part
// no dependencies
package jse_pkg;

    // input request: one utf-16 code unit with string marks
    typedef struct packed {
        logic [15:0] code_unit;
        logic        first_unit;
        logic        last_unit;
        logic        empty_string;
    } t_in;

    // output request: one byte of escaped utf-8
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic [1:0] error_code;
    } t_out;

    localparam int JOB_BYTES = 8;
    localparam int JOB_IDX_W = $clog2(JOB_BYTES);
    localparam int JOB_CNT_W = $clog2(JOB_BYTES + 1);

    // bytes made by one code unit, issued by the back part in order
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [JOB_CNT_W-1:0]      count;
        logic                      fin;
        logic [1:0]                err;
    } t_job;

    localparam int QDEPTH = 2;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_HIGH = 2'd1;
    localparam logic [1:0] ERR_LOW  = 2'd2;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_U = 8'h75;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    // lowercase hex digit of a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = CH_ZERO + {4'd0, v};
        end else begin
            r = CH_LOW_A + {4'd0, v} - 8'd10;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/json_string_escape_utf16_to_utf8.sv =====
// json string escaper, utf-16 code units in, escaped quoted utf-8 bytes out
// top level: front classifier, two-entry job queue, byte issuer; uses jse_pkg
//
// usage
//   input channel carries one code unit per request with first, last and
//   empty-string marks; output channel carries one byte per request with a
//   last mark and an error code (1 lone high, 2 lone low surrogate)
//   each unit turns into a job of up to eight bytes in the front part;
//   the back part sends one byte per cycle from the oldest job while the output is not stalled
//   the first byte of a unit passes through a queue entry and then the output register
//   throughput: one output byte per cycle while i_out_stall is low; a unit
//   that makes no bytes is accepted without pushing a job;
//   input takes one unit per cycle while the queue has room
//   reset: surrogate and drop state cleared, queue and output register empty
//   output stall: the output register holds its byte, the queue fills, and
//   o_in_stall rises once both queue entries are taken
module json_string_escape_utf16_to_utf8 import jse_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    logic q_full, q_empty, push, pop;
    t_job push_job, head_job;

    // classify and build jobs
    jse_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    // decoupling queue
    jse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    // byte issue
    jse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/core/jse_front.sv =====
// front part: takes code units, tracks surrogate and drop state, and builds
// a job holding every byte the unit produces; depends on jse_pkg
module jse_front import jse_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    input  logic i_q_full,
    output logic o_push,
    output t_job o_job
);

    logic [9:0] r_pend_high, n_pend_high;
    logic       r_pend_valid, n_pend_valid;
    logic       r_dropping, n_dropping;

    logic        accept;
    logic [15:0] u;
    logic        is_high, is_low;
    logic [7:0]  esc;
    logic [5:0][7:0] unit_bytes;
    logic [2:0]  unit_len;
    logic [10:0] plane;
    logic [5:0][7:0] body_bytes;
    logic [2:0]  body_len;
    logic        use_body;
    logic [JOB_CNT_W-1:0] n;
    t_job        job;

    assign u       = i_in_data.code_unit;
    assign is_high = (u[15:10] == 6'b110110);
    assign is_low  = (u[15:10] == 6'b110111);
    assign accept  = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

    // short escape decoder
    always_comb begin
        unique case (u)
            16'h0022: esc = CH_QUOTE;
            16'h005C: esc = CH_BSLASH;
            16'h0008: esc = 8'h62;
            16'h0009: esc = 8'h74;
            16'h000A: esc = 8'h6E;
            16'h000C: esc = 8'h66;
            16'h000D: esc = 8'h72;
            default:  esc = 8'h00;
        endcase
    end

    // bytes of a plain unit
    always_comb begin
        unit_bytes = '0;
        if (esc != 8'h00) begin
            unit_bytes[0] = CH_BSLASH;
            unit_bytes[1] = esc;
            unit_len = 3'd2;
        end else if (u < {8'd0, CTRL_LIMIT}) begin
            unit_bytes[0] = CH_BSLASH;
            unit_bytes[1] = CH_U;
            unit_bytes[2] = CH_ZERO;
            unit_bytes[3] = CH_ZERO;
            unit_bytes[4] = hex_digit({3'd0, u[4]});
            unit_bytes[5] = hex_digit(u[3:0]);
            unit_len = 3'd6;
        end else if (u < 16'h0080) begin
            unit_bytes[0] = u[7:0];
            unit_len = 3'd1;
        end else if (u < 16'h0800) begin
            unit_bytes[0] = {3'b110, u[10:6]};
            unit_bytes[1] = {2'b10, u[5:0]};
            unit_len = 3'd2;
        end else begin
            unit_bytes[0] = {4'b1110, u[15:12]};
            unit_bytes[1] = {2'b10, u[11:6]};
            unit_bytes[2] = {2'b10, u[5:0]};
            unit_len = 3'd3;
        end
    end

    // joined surrogate pair: code point bits 20:10 are high half plus 0x40
    assign plane = {1'b0, r_pend_high} + 11'd64;

    // main classification and job build
    always_comb begin
        n_pend_high  = r_pend_high;
        n_pend_valid = r_pend_valid;
        n_dropping   = r_dropping;
        job          = '0;
        n            = '0;
        use_body     = 1'b0;
        body_bytes   = unit_bytes;
        body_len     = unit_len;
        if (i_in_data.empty_string) begin
            n_pend_high  = '0;
            n_pend_valid = 1'b0;
            n_dropping   = 1'b0;
            job.bytes[0] = CH_QUOTE;
            job.bytes[1] = CH_QUOTE;
            n            = JOB_CNT_W'(2);
            job.fin      = 1'b1;
        end else begin
            if (i_in_data.first_unit) begin
                n_pend_valid = 1'b0;
                n_dropping   = 1'b0;
                job.bytes[0] = CH_QUOTE;
                n            = JOB_CNT_W'(1);
            end
            if (n_dropping) begin
                if (i_in_data.last_unit) begin
                    n_dropping = 1'b0;
                end
            end else if (n_pend_valid) begin
                n_pend_valid = 1'b0;
                if (!is_low) begin
                    n_dropping = !i_in_data.last_unit;
                    job.bytes[n[JOB_IDX_W-1:0]] = 8'h00;
                    n       = n + JOB_CNT_W'(1);
                    job.fin = 1'b1;
                    job.err = ERR_HIGH;
                end else begin
                    body_bytes    = '0;
                    body_bytes[0] = {5'b11110, plane[10:8]};
                    body_bytes[1] = {2'b10, plane[7:2]};
                    body_bytes[2] = {2'b10, plane[1:0], u[9:6]};
                    body_bytes[3] = {2'b10, u[5:0]};
                    body_len      = 3'd4;
                    use_body      = 1'b1;
                    n_pend_high   = '0;
                end
            end else if (is_high) begin
                if (i_in_data.last_unit) begin
                    job.bytes[n[JOB_IDX_W-1:0]] = 8'h00;
                    n       = n + JOB_CNT_W'(1);
                    job.fin = 1'b1;
                    job.err = ERR_HIGH;
                end else begin
                    n_pend_high  = u[9:0];
                    n_pend_valid = 1'b1;
                end
            end else if (is_low) begin
                n_dropping = !i_in_data.last_unit;
                job.bytes[n[JOB_IDX_W-1:0]] = 8'h00;
                n       = n + JOB_CNT_W'(1);
                job.fin = 1'b1;
                job.err = ERR_LOW;
            end else begin
                use_body = 1'b1;
            end
            // copy body bytes, then the closing quote
            if (use_body) begin
                for (int k = 0; k < 6; k++) begin
                    if (3'(k) < body_len) begin
                        job.bytes[n[JOB_IDX_W-1:0]] = body_bytes[k];
                        n = n + JOB_CNT_W'(1);
                    end
                end
                if (i_in_data.last_unit) begin
                    job.bytes[n[JOB_IDX_W-1:0]] = CH_QUOTE;
                    n       = n + JOB_CNT_W'(1);
                    job.fin = 1'b1;
                end
            end
        end
        job.count = n;
    end

    assign o_job  = job;
    assign o_push = accept && (job.count != '0);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_high  <= '0;
            r_pend_valid <= 1'b0;
            r_dropping   <= 1'b0;
        end else if (accept) begin
            r_pend_high  <= n_pend_high;
            r_pend_valid <= n_pend_valid;
            r_dropping   <= n_dropping;
        end
    end

endmodule

// ===== rtl/core/jse_queue.sv =====
// short job queue between the front and back parts
// depends on jse_pkg for the job type and depth
module jse_queue import jse_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_job             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/jse_back.sv =====
// back part: walks the head job one byte a cycle into the output register while the output is not stalled
// depends on jse_pkg
module jse_back import jse_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_empty,
    input  t_job i_head,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    logic [JOB_IDX_W-1:0] r_idx;
    logic                 r_valid;
    t_out                 r_data;
    logic                 load;
    logic                 at_end;
    logic [JOB_IDX_W-1:0] last_idx;

    assign last_idx = JOB_IDX_W'(i_head.count - JOB_CNT_W'(1));
    assign at_end   = (r_idx == last_idx);
    assign load     = !i_q_empty && (!r_valid || !i_out_stall);
    assign o_pop    = load && at_end;

    // byte index within the head job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (load) begin
            r_idx <= at_end ? '0 : r_idx + JOB_IDX_W'(1);
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data.out_byte   <= i_head.bytes[r_idx];
            r_data.last_byte  <= at_end && i_head.fin;
            r_data.error_code <= at_end ? i_head.err : ERR_NONE;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

// ===== tb/testbench.sv =====
// testbench for json_string_escape_utf16_to_utf8: directed and random utf-16 strings
// predicts escaped utf-8 output bytes in-line and checks every output request
// depends on jse_pkg and the escaper top level
module testbench;
    import jse_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_UNITS = 150;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    // short escape letters
    localparam logic [7:0] ESC_B = 8'h62;
    localparam logic [7:0] ESC_T = 8'h74;
    localparam logic [7:0] ESC_N = 8'h6E;
    localparam logic [7:0] ESC_F = 8'h66;
    localparam logic [7:0] ESC_R = 8'h72;
    localparam logic [15:0][7:0] HEX_CHARS = "0123456789abcdef";

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_stall;
    t_in  in_data;
    logic out_valid;
    logic out_stall;
    t_out out_data;

    // predicted escaper state
    logic [9:0] held_high;
    logic       held_valid;
    logic       skipping;

    t_out        expected_bytes[$];
    logic [15:0] str_units[$];
    int          mismatches;
    int          units_counted;
    int          cycle_count;
    bit          no_idle;

    json_string_escape_utf16_to_utf8 u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic l,
                                      input logic [1:0] e);
        expected_bytes.push_back(t_out'{out_byte: b, last_byte: l, error_code: e});
    endfunction

    // escaped utf-8 bytes of one non-surrogate code unit
    function automatic void escape_plain(input logic [15:0] cu);
        logic [7:0] short_ch;
        short_ch = 8'h00;
        case (cu)
            16'h0022: short_ch = CH_QUOTE;
            16'h005C: short_ch = CH_BSLASH;
            16'h0008: short_ch = ESC_B;
            16'h0009: short_ch = ESC_T;
            16'h000A: short_ch = ESC_N;
            16'h000C: short_ch = ESC_F;
            16'h000D: short_ch = ESC_R;
            default: short_ch = 8'h00;
        endcase
        if (short_ch != 8'h00) begin
            push_byte(CH_BSLASH, 1'b0, ERR_NONE);
            push_byte(short_ch, 1'b0, ERR_NONE);
        end else if (cu < {8'h00, CTRL_LIMIT}) begin
            push_byte(CH_BSLASH, 1'b0, ERR_NONE);
            push_byte(CH_U, 1'b0, ERR_NONE);
            push_byte(CH_ZERO, 1'b0, ERR_NONE);
            push_byte(CH_ZERO, 1'b0, ERR_NONE);
            push_byte(HEX_CHARS[4'd15 - cu[7:4]], 1'b0, ERR_NONE);
            push_byte(HEX_CHARS[4'd15 - cu[3:0]], 1'b0, ERR_NONE);
        end else if (cu < 16'h0080) begin
            push_byte(cu[7:0], 1'b0, ERR_NONE);
        end else if (cu < 16'h0800) begin
            push_byte({3'b110, cu[10:6]}, 1'b0, ERR_NONE);
            push_byte({2'b10, cu[5:0]}, 1'b0, ERR_NONE);
        end else begin
            push_byte({4'b1110, cu[15:12]}, 1'b0, ERR_NONE);
            push_byte({2'b10, cu[11:6]}, 1'b0, ERR_NONE);
            push_byte({2'b10, cu[5:0]}, 1'b0, ERR_NONE);
        end
    endfunction

    // predict the bytes of one accepted unit; returns 1 when the unit is skipped
    function automatic bit model_escape(input t_in u);
        logic [15:0] cu;
        logic        is_hi;
        logic        is_lo;
        logic [20:0] cp;
        cu = u.code_unit;
        is_hi = (cu[15:10] == 6'b110110);
        is_lo = (cu[15:10] == 6'b110111);
        if (u.empty_string) begin
            held_high = '0;
            held_valid = 1'b0;
            skipping = 1'b0;
            push_byte(CH_QUOTE, 1'b0, ERR_NONE);
            push_byte(CH_QUOTE, 1'b1, ERR_NONE);
            return 1'b0;
        end
        if (u.first_unit) begin
            held_valid = 1'b0;
            skipping = 1'b0;
            push_byte(CH_QUOTE, 1'b0, ERR_NONE);
        end
        // after an error, units up to the last are dropped
        if (skipping) begin
            if (u.last_unit) skipping = 1'b0;
            return 1'b1;
        end
        if (held_valid) begin
            held_valid = 1'b0;
            if (!is_lo) begin
                skipping = !u.last_unit;
                push_byte(8'h00, 1'b1, ERR_HIGH);
                return 1'b0;
            end
            cp = 21'h10000 + {1'b0, held_high, cu[9:0]};
            push_byte({5'b11110, cp[20:18]}, 1'b0, ERR_NONE);
            push_byte({2'b10, cp[17:12]}, 1'b0, ERR_NONE);
            push_byte({2'b10, cp[11:6]}, 1'b0, ERR_NONE);
            push_byte({2'b10, cp[5:0]}, 1'b0, ERR_NONE);
            held_high = '0;
        end else if (is_hi) begin
            if (u.last_unit) begin
                push_byte(8'h00, 1'b1, ERR_HIGH);
                return 1'b0;
            end
            held_high = cu[9:0];
            held_valid = 1'b1;
            return 1'b0;
        end else if (is_lo) begin
            skipping = !u.last_unit;
            push_byte(8'h00, 1'b1, ERR_LOW);
            return 1'b0;
        end else begin
            escape_plain(cu);
        end
        if (u.last_unit) push_byte(CH_QUOTE, 1'b1, ERR_NONE);
        return 1'b0;
    endfunction

    // send one input request, predict on acceptance
    task automatic send_unit(input t_in u);
        int gap;
        bit ignored;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= u;
        do @(posedge i_clk); while (in_stall);
        ignored = model_escape(u);
        if (!ignored) units_counted++;
    endtask

    // send the queued units as one string
    task automatic send_str_units(input bit with_first, input bit with_last);
        int n;
        n = str_units.size();
        for (int i = 0; i < n; i++) begin
            send_unit(t_in'{code_unit: str_units[i],
                            first_unit: with_first && (i == 0),
                            last_unit: with_last && (i == n - 1),
                            empty_string: 1'b0});
        end
    endtask

    // hold off input until every predicted byte is out
    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_short_escapes();
        str_units = '{16'h0022, 16'h005C, 16'h0008, 16'h0009, 16'h000A,
                      16'h000C, 16'h000D};
        send_str_units(1'b1, 1'b1);
    endtask

    task automatic test_control_escapes();
        str_units = '{16'h0000, 16'h001F, 16'h001B};
        send_str_units(1'b1, 1'b1);
    endtask

    // boundaries of one, two and three byte forms, and the widest pair
    task automatic test_utf8_lengths();
        str_units = '{16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF,
                      16'hDBFF, 16'hDFFF};
        send_str_units(1'b1, 1'b1);
    endtask

    task automatic test_surrogate_errors();
        // high surrogate followed by a non-low unit, rest dropped
        str_units = '{16'hD800, 16'h0041, 16'h0042};
        send_str_units(1'b1, 1'b1);
        // high surrogate as the last unit
        str_units = '{16'hDBFF};
        send_str_units(1'b1, 1'b1);
        // low surrogate as the last unit
        str_units = '{16'h0041, 16'hDC00};
        send_str_units(1'b1, 1'b1);
        // low surrogate without a high one, first of two units
        str_units = '{16'hDFFF, 16'h0041};
        send_str_units(1'b1, 1'b1);
    endtask

    task automatic test_string_framing();
        // unterminated string with a held high surrogate, abandoned by a new first
        str_units = '{16'hD800};
        send_str_units(1'b1, 1'b0);
        str_units = '{16'h0041, 16'h0042};
        send_str_units(1'b1, 1'b1);
        // unit without an open string
        str_units = '{16'h0043};
        send_str_units(1'b0, 1'b1);
        // empty string, once with every other field set and once with them clear
        send_unit(t_in'{code_unit: 16'hFFFF, first_unit: 1'b1, last_unit: 1'b1,
                        empty_string: 1'b1});
        send_unit(t_in'{code_unit: 16'h0000, first_unit: 1'b0, last_unit: 1'b0,
                        empty_string: 1'b1});
    endtask

    // one random code unit of a chosen class, or a surrogate pair
    function automatic void add_random_unit(input int room);
        int          kind;
        logic [15:0] cu;
        kind = $urandom_range(0, 15);
        if (kind >= 11 && kind <= 12 && room < 2) kind = 0;
        case (kind)
            0, 1, 2, 3, 4: str_units.push_back(16'($urandom_range(16'h20, 16'h7E)));
            5: begin
                case ($urandom_range(0, 6))
                    0: cu = 16'h0022;
                    1: cu = 16'h005C;
                    2: cu = 16'h0008;
                    3: cu = 16'h0009;
                    4: cu = 16'h000A;
                    5: cu = 16'h000C;
                    default: cu = 16'h000D;
                endcase
                str_units.push_back(cu);
            end
            6: str_units.push_back(16'($urandom_range(0, 16'h1F)));
            7, 8: str_units.push_back(16'($urandom_range(16'h80, 16'h7FF)));
            9, 10: begin
                cu = 16'($urandom_range(16'h800, 16'hFFFF));
                if (cu[15:11] == 5'b11011) cu[15] = 1'b0;
                str_units.push_back(cu);
            end
            11, 12: begin
                str_units.push_back({6'b110110, 10'($urandom)});
                str_units.push_back({6'b110111, 10'($urandom)});
            end
            13: str_units.push_back({6'b110110, 10'($urandom)});
            14: str_units.push_back({6'b110111, 10'($urandom)});
            default: str_units.push_back(16'($urandom));
        endcase
    endfunction

    // mostly well-formed strings, some broken framing and raw noise
    task automatic test_random_strings();
        int  len;
        int  pick;
        bit  drained;
        drained = 1'b0;
        units_counted = 0;
        while (units_counted < RANDOM_UNITS) begin
            no_idle = (units_counted >= 60 && units_counted < 100);
            if (!drained && units_counted >= 120) begin
                wait_all_results();
                drained = 1'b1;
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                send_unit(t_in'{code_unit: 16'($urandom), first_unit: 1'($urandom),
                                last_unit: 1'($urandom), empty_string: 1'b1});
            end else if (pick == 1) begin
                send_unit(t_in'(19'($urandom)));
            end else begin
                str_units.delete();
                len = $urandom_range(1, 6);
                while (str_units.size() < len) add_random_unit(len - str_units.size());
                send_str_units($urandom_range(0, 15) != 0, $urandom_range(0, 15) != 0);
            end
        end
        no_idle = 1'b0;
    endtask

    // output side stalls
    initial begin : out_side
        int gap;
        out_stall = 1'b0;
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!out_valid);
        end
    end

    // compare each output request with the oldest prediction
    always @(posedge i_clk) begin : check_bytes
        t_out want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected byte %h last %b err %0d", out_data.out_byte,
                             out_data.last_byte, out_data.error_code);
            end else begin
                want = expected_bytes.pop_front();
                if (out_data.out_byte !== want.out_byte ||
                    out_data.last_byte !== want.last_byte ||
                    out_data.error_code !== want.error_code) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected byte %h last %b err %0d, got %h %b %0d",
                                 want.out_byte, want.last_byte, want.error_code,
                                 out_data.out_byte, out_data.last_byte,
                                 out_data.error_code);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        no_idle = 1'b0;
        mismatches = 0;
        units_counted = 0;
        cycle_count = 0;
        held_high = '0;
        held_valid = 1'b0;
        skipping = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_escapes();
        test_control_escapes();
        test_utf8_lengths();
        test_surrogate_errors();
        test_string_framing();
        wait_all_results();
        test_random_strings();

        wait_all_results();
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ===== json_string_escape_utf16_to_utf8.f =====
rtl/core/jse_pkg.sv
rtl/core/jse_front.sv
rtl/core/jse_queue.sv
rtl/core/jse_back.sv
rtl/core/json_string_escape_utf16_to_utf8.sv
tb/testbench.sv
